### rtl/core/imuth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuth_pkg
// shared types, constants and the arctangent table for the tilt/heading unit
// ----------------------------------------------------------------------------
package imuth_pkg;

	localparam int CordicSteps = 18;
	localparam int TableLen    = 24;
	localparam int StepW       = 5;
	localparam int ZW          = 26;
	localparam int CW          = 36;
	localparam int FracBits    = 16;
	localparam logic [6:0] DeadzoneReset = 7'd15;
	localparam logic [8:0] FullTurn = 9'd360;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_PITCH,
		ST_ROLL,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} cordic_ctl_t;

	function automatic logic signed [ZW-1:0] atan_entry(input logic [StepW-1:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0:    r = 26'sd2949337;
			5'd1:    r = 26'sd1741095;
			5'd2:    r = 26'sd919947;
			5'd3:    r = 26'sd466979;
			5'd4:    r = 26'sd234396;
			5'd5:    r = 26'sd117312;
			5'd6:    r = 26'sd58670;
			5'd7:    r = 26'sd29337;
			5'd8:    r = 26'sd14669;
			5'd9:    r = 26'sd7335;
			5'd10:   r = 26'sd3667;
			5'd11:   r = 26'sd1834;
			5'd12:   r = 26'sd917;
			5'd13:   r = 26'sd458;
			5'd14:   r = 26'sd229;
			5'd15:   r = 26'sd115;
			5'd16:   r = 26'sd57;
			5'd17:   r = 26'sd29;
			5'd18:   r = 26'sd14;
			5'd19:   r = 26'sd7;
			5'd20:   r = 26'sd4;
			5'd21:   r = 26'sd2;
			5'd22:   r = 26'sd1;
			default: r = 26'sd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/imu_tilt_heading_estimator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_tilt_heading_estimator_unit
// heading integration plus pitch and roll from one imu sample
// ----------------------------------------------------------------------------
// usage
//   in channel: accel_x/y/z and yaw_rate with in_valid, in_stall; a request is
//   taken when in_valid is high and in_stall low. in_stall is high while a
//   sample is being worked or its result is still waiting.
//   out channel: heading_deg, pitch_deg, roll_deg, tilt_step with out_valid
//   and out_stall from the receiver. the result holds while stalled.
//   sequence: the square root runs first, then two cordic passes, pitch then
//   roll, on the one shared rotator; out_valid rises when the roll pass ends.
//   a new request is taken at the earliest in the cycle after the result is
//   taken, so a new sample is not accepted before the last one is through.
//   heading is updated at acceptance: yaw_rate/32 toward zero, wrapped mod 360
//   by a short chain of compare-and-subtract steps after a positive offset.
//   tilt_deadzone is written through cfg_we/cfg_wdata; the user must write it
//   only while idle, as the block itself does not enforce this.
//   reset clears the heading to 0, deadzone to 15 and the sequencer to idle.
// ----------------------------------------------------------------------------
module imu_tilt_heading_estimator_unit import imuth_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] yaw_rate,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [8:0]         heading_deg,
	output logic signed [7:0]  pitch_deg,
	output logic signed [8:0]  roll_deg,
	output logic signed [1:0]  tilt_step
);

	seq_state_t state_q, state_d;
	logic [6:0]         deadzone_q;
	logic [8:0]         heading_q;
	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [7:0]  pitch_q;
	logic signed [8:0]  roll_q;
	logic signed [1:0]  step_q;
	logic               in_take;

	// sample request taken only when idle
	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_valid = (state_q == ST_DONE);

	// heading step: truncating divide by 32
	logic signed [10:0] rate_div;
	logic signed [11:0] h_sum;
	logic [11:0]        h_pos, h_a, h_b;
	logic [8:0]         h_next;
	assign rate_div = (yaw_rate < 0) ? -11'((-17'(yaw_rate)) >>> 5) : 11'(yaw_rate >>> 5);
	assign h_sum = $signed({3'b000, heading_q}) + 12'(rate_div);
	// offset by three turns so the sum is never negative, then fold down
	assign h_pos = 12'(h_sum + 12'sd1080);
	always_comb begin
		h_a = (h_pos >= 12'd1440) ? h_pos - 12'd1440 : h_pos;
		h_b = (h_a >= 12'd720) ? h_a - 12'd720 : h_a;
		h_next = (h_b >= 12'd360) ? 9'(h_b - 12'd360) : 9'(h_b);
	end

	// square root of ay^2+az^2
	logic [31:0] sq_y, sq_z, radicand;
	logic [16:0] root;
	logic        sqrt_done, sqrt_start;
	assign sq_y = 32'($signed(accel_y) * $signed(accel_y));
	assign sq_z = 32'($signed(accel_z) * $signed(accel_z));
	assign radicand = sq_y + sq_z;
	assign sqrt_start = in_take;

	imuth_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start),
		.radicand(radicand), .done(sqrt_done), .root(root)
	);

	// shared cordic: pitch pass then roll pass; operands are sampled at start
	cordic_ctl_t        cctl;
	logic signed [17:0] c_y, c_x;
	logic               c_done;
	logic signed [8:0]  c_angle;

	always_comb begin
		if (state_q == ST_SQRT) begin
			c_y = 18'(ax_q);
			c_x = $signed({1'b0, root});
		end else begin
			c_y = 18'(ay_q);
			c_x = 18'(az_q);
		end
	end

	assign cctl.start = sqrt_done || (state_q == ST_PITCH && c_done);
	assign cctl.busy  = (state_q == ST_PITCH) || (state_q == ST_ROLL);
	assign cctl.done  = c_done;

	imuth_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .ctl_in(cctl),
		.yv(c_y), .xv(c_x), .done(c_done), .angle(c_angle)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_take) state_d = ST_SQRT;
			ST_SQRT:  if (sqrt_done) state_d = ST_PITCH;
			ST_PITCH: if (c_done) state_d = ST_ROLL;
			ST_ROLL:  if (c_done) state_d = ST_DONE;
			ST_DONE:  if (!out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			heading_q  <= '0;
			deadzone_q <= DeadzoneReset;
		end else begin
			state_q <= state_d;
			if (cfg_we) deadzone_q <= cfg_wdata;
			if (in_take) heading_q <= h_next;
		end
	end

	// payload registers
	logic signed [8:0] dz_s;
	assign dz_s = $signed({2'b00, deadzone_q});
	always_ff @(posedge clk) begin
		if (in_take) begin
			ax_q <= accel_x;
			ay_q <= accel_y;
			az_q <= accel_z;
		end
		if (state_q == ST_PITCH && c_done) begin
			pitch_q <= 8'(c_angle);
			step_q  <= (c_angle > dz_s) ? 2'sd1 : ((c_angle < -dz_s) ? -2'sd1 : 2'sd0);
		end
		if (state_q == ST_ROLL && c_done) roll_q <= c_angle;
	end

	assign heading_deg = heading_q;
	assign pitch_deg   = pitch_q;
	assign roll_deg    = roll_q;
	assign tilt_step   = step_q;

endmodule

### rtl/core/imuth_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuth_isqrt
// bit-pair integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module imuth_isqrt import imuth_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] radicand,
	output logic        done,
	output logic [16:0] root
);

	logic [31:0] rem_q;
	logic [31:0] root_q;
	logic [31:0] bit_q;
	logic        busy_q;
	logic [32:0] trial;

	assign trial = {1'b0, root_q} + {1'b0, bit_q};
	assign root  = root_q[16:0];
	assign done  = busy_q && (bit_q == 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= radicand;
			root_q <= '0;
			bit_q  <= 32'h4000_0000;
		end else if (busy_q && bit_q != 32'd0) begin
			if ({1'b0, rem_q} >= trial) begin
				rem_q  <= rem_q - trial[31:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

### rtl/core/imuth_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuth_cordic
// vectoring cordic, one micro-rotation per cycle, whole degrees out
// ----------------------------------------------------------------------------
module imuth_cordic import imuth_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cordic_ctl_t        ctl_in,
	input  logic signed [17:0] yv,
	input  logic signed [17:0] xv,
	output logic               done,
	output logic signed [8:0]  angle
);

	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [StepW-1:0]     i_q;
	logic                 busy_q;
	logic                 zero_q;
	logic signed [CW-1:0] xs, ys, x0, y0;
	logic signed [ZW-1:0] z0, tab;
	logic signed [ZW-1:0] quarter;
	logic [StepW-1:0]     last;

	localparam int Iters = (CordicSteps < TableLen) ? CordicSteps : TableLen;
	assign last    = StepW'(Iters - 1);
	assign quarter = atan_entry('0) <<< 1;

	always_comb begin
		x0 = CW'(xv) <<< 12;
		y0 = CW'(yv) <<< 12;
		z0 = '0;
		if (x0 < 0) begin
			if (y0 >= 0) begin
				x0 = CW'(yv) <<< 12;
				y0 = -(CW'(xv) <<< 12);
				z0 = quarter;
			end else begin
				x0 = -(CW'(yv) <<< 12);
				y0 = CW'(xv) <<< 12;
				z0 = -quarter;
			end
		end
	end

	assign xs  = x_q >>> i_q;
	assign ys  = y_q >>> i_q;
	assign tab = atan_entry(i_q);
	assign done = busy_q && (i_q == last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (ctl_in.start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			x_q    <= x0;
			y_q    <= y0;
			z_q    <= z0;
			i_q    <= '0;
			zero_q <= (xv == 18'sd0) && (yv == 18'sd0);
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - tab;
			end
			i_q <= i_q + 1'b1;
		end
	end

	// the last update is folded in here so the angle is ready with done
	logic signed [ZW-1:0] zf, zfn;
	assign zf  = (y_q >= 0) ? z_q + tab : z_q - tab;
	assign zfn = -zf;
	assign angle = zero_q ? 9'sd0 :
		(zf < 0) ? -$signed(9'(zfn >>> FracBits)) : 9'(zf >>> FracBits);

	logic unused_ctl;
	assign unused_ctl = ^{ctl_in.busy, ctl_in.done};

endmodule

### rtl/core/imuth_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuth_checker
// port-level checks for the tilt/heading unit
// ----------------------------------------------------------------------------
module imuth_checker import imuth_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [8:0]        heading_deg,
	input logic signed [1:0] tilt_step
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(heading_deg))
		else $error("result dropped under stall");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heading_deg < FullTurn && tilt_step != -2'sd2)
		else $error("result out of range");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("request overlapped");

	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

endmodule

bind imu_tilt_heading_estimator_unit imuth_checker u_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.heading_deg(heading_deg), .tilt_step(tilt_step)
);
